### rtl/itde_pkg.sv
// Shared types, code constants and byte-forming functions of the index table delta encoder.
package itde_pkg;

  // Sizing
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxBytes   = 7;
  localparam int unsigned CountW     = $clog2(MaxBytes + 1);

  // Stream codes
  localparam logic [7:0] RunOne   = 8'h00;
  localparam logic [7:0] RunShort = 8'hE0;
  localparam logic [7:0] RunLong  = 8'hF0;
  localparam logic [7:0] EscByte  = 8'hF1;
  localparam logic [7:0] EscWord  = 8'hF2;
  localparam logic [7:0] Lit3     = 8'hE0;
  localparam logic [7:0] Lit4     = 8'hE1;
  localparam logic [7:0] Zz2      = 8'h80;
  localparam logic [7:0] Zz3      = 8'hC0;

  // One coded item: bytes in stream order from index 0, count of 1..7 bytes
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } rec_t;

  typedef struct packed {
    logic [15:0] b;
    logic [1:0]  n;
  } run_code_t;

  typedef struct packed {
    logic [39:0] b;
    logic [2:0]  n;
  } val_code_t;

  // Run flush code; unused byte lanes are zero
  function automatic run_code_t run_code(input logic [7:0] n);
    run_code_t r;
    r = '0;
    if (n == 8'd0) begin
      r.n = 2'd0;
    end else if (n == 8'd1) begin
      r.b[7:0] = RunOne;
      r.n = 2'd1;
    end else if (n < 8'd16) begin
      r.b[7:0] = RunShort + n;
      r.n = 2'd1;
    end else begin
      r.b[7:0]  = RunLong;
      r.b[15:8] = n - 8'd16;
      r.n = 2'd2;
    end
    return r;
  endfunction

  // Value code: zigzag error, escapes on the difference, then literals
  function automatic val_code_t val_code(input logic [34:0] z, input logic [32:0] k,
                                         input logic [30:0] v);
    val_code_t c;
    c = '0;
    if (z < 35'd128) begin
      c.b[7:0] = z[7:0];
      c.n = 3'd1;
    end else if (z < 35'd16384) begin
      c.b[7:0]  = Zz2 | {2'b00, z[13:8]};
      c.b[15:8] = z[7:0];
      c.n = 3'd2;
    end else if (k < 33'd256) begin
      c.b[7:0]  = EscByte;
      c.b[15:8] = k[7:0];
      c.n = 3'd2;
    end else if (z < 35'd2097152) begin
      c.b[7:0]   = Zz3 | {3'b000, z[20:16]};
      c.b[15:8]  = z[15:8];
      c.b[23:16] = z[7:0];
      c.n = 3'd3;
    end else if (k < 33'd65536) begin
      c.b[7:0]   = EscWord;
      c.b[15:8]  = k[15:8];
      c.b[23:16] = k[7:0];
      c.n = 3'd3;
    end else if (v < 31'd16777216) begin
      c.b[7:0]   = Lit3;
      c.b[15:8]  = v[23:16];
      c.b[23:16] = v[15:8];
      c.b[31:24] = v[7:0];
      c.n = 3'd4;
    end else begin
      c.b[7:0]   = Lit4;
      c.b[15:8]  = {1'b0, v[30:24]};
      c.b[23:16] = v[23:16];
      c.b[31:24] = v[15:8];
      c.b[39:32] = v[7:0];
      c.n = 3'd5;
    end
    return c;
  endfunction

endpackage

### rtl/index_table_delta_encoder.sv
// Top level of the index table delta encoder: front end, item queue, byte serializer.
//
// Input stream s_axis: one table index per transfer. tdata[30:0] is the value,
// tlast marks the end of a table (flushes a pending run), tuser[0] marks the
// first value of a table (clears predictor and run).
// Output stream m_axis: one encoded byte per transfer, tlast on the last byte
// that one input value caused. A value that only extends a run gives no bytes.
// A coded value is registered in the queue; its first byte is offered at the queue head.
// Throughput: one input per cycle while values code to one byte each and the
// receiver takes every byte; a value coding to n bytes (1 to 7) goes out byte
// by byte on the single byte-wide output port. Up to QueueDepth coded values
// wait in the queue, so the input keeps running during multi-byte codes until
// the queue fills. When the receiver stalls, bytes wait in the queue and
// s_axis_tready drops only once the queue is full.
// Reset clears predictor, run count, queue and serializer; no clearing pass.
module index_table_delta_encoder import itde_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] ignored
  input  logic        s_axis_tlast,   // end_of_table
  input  logic [0:0]  s_axis_tuser,   // [0] first_of_table
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // last_byte
);

  logic accept, push, full, pop, empty;
  rec_t rec, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  itde_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .value_i  (s_axis_tdata[30:0]),
    .first_i  (s_axis_tuser[0]),
    .end_i    (s_axis_tlast),
    .push_o   (push),
    .rec_o    (rec)
  );

  itde_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  itde_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule

### rtl/itde_front.sv
// Front end: predictor state, run counter and classification of each value into a coded item.
module itde_front import itde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [30:0] value_i,
  input  logic        first_i,
  input  logic        end_i,
  output logic        push_o,
  output rec_t        rec_o
);

  logic [30:0] prev_q, prev_e;
  logic [32:0] pred_q, pred_d, pred_e;   // two's complement prediction
  logic [7:0]  run_q, run_d, run_e;
  logic [33:0] err;
  logic [31:0] dif;
  logic [34:0] z;
  logic [32:0] k;
  logic [8:0]  run_inc;
  run_code_t   rs, re;
  val_code_t   cs;
  logic [55:0] cat;
  rec_t        rec;

  // First of table clears predictor and run before coding
  assign prev_e = first_i ? '0 : prev_q;
  assign pred_e = first_i ? '0 : pred_q;
  assign run_e  = first_i ? '0 : run_q;

  // Prediction error and step, zigzag mapped
  assign err = {3'b000, value_i} - {pred_e[32], pred_e};
  assign dif = {1'b0, value_i} - {1'b0, prev_e};
  assign z   = {err, 1'b0} ^ {35{err[33]}};
  assign k   = {dif, 1'b0} ^ {33{dif[31]}};

  // Next prediction 2*v - prev, kept ready for the following item
  assign pred_d = {1'b0, value_i, 1'b0} - {2'b00, prev_e};

  assign run_inc = {1'b0, run_e} + 9'd1;
  assign rs = run_code(run_e);
  assign re = run_code(run_inc[7:0]);
  assign cs = val_code(z, k, value_i);

  // Byte assembly
  always_comb begin
    rec   = '0;
    run_d = run_e;
    cat   = '0;
    if (err == '0) begin
      if (run_inc[8]) begin
        rec.bytes[0] = RunLong;
        rec.bytes[1] = RunLong;
        rec.count    = CountW'(2);
        run_d        = '0;
      end else begin
        run_d = run_inc[7:0];
        if (end_i) begin
          rec.bytes[0] = re.b[7:0];
          rec.bytes[1] = re.b[15:8];
          rec.count    = CountW'(re.n);
          run_d        = '0;
        end
      end
    end else begin
      // run flush, then value code right behind it
      case (rs.n)
        2'd0:    cat = {16'b0, cs.b};
        2'd1:    cat = {8'b0, cs.b, 8'b0};
        2'd2:    cat = {cs.b, 16'b0};
        default: cat = {16'b0, cs.b};
      endcase
      rec.bytes = cat | {40'b0, rs.b};
      rec.count = CountW'(rs.n) + CountW'(cs.n);
      run_d     = '0;
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pred_q <= '0;
      run_q  <= '0;
    end else if (accept_i) begin
      prev_q <= value_i;
      pred_q <= pred_d;
      run_q  <= run_d;
    end
  end

  assign push_o = accept_i && (rec.count != '0);
  assign rec_o  = rec;

endmodule

### rtl/itde_queue.sv
// Short queue of coded items between front end and byte serializer.
module itde_queue import itde_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/itde_back.sv
// Back end: walks the bytes of the head item onto the output stream.
module itde_back import itde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  rec_t       head_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic [CountW-1:0] idx_q, idx_d;
  logic              xfer;

  assign valid_o = !empty_i;
  assign byte_o  = head_i.bytes[idx_q];
  assign last_o  = (idx_q == head_i.count - CountW'(1));
  assign xfer    = valid_o && ready_i;
  assign pop_o   = xfer && last_o;

  // Byte index within the head item
  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = last_o ? '0 : idx_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

### test/tb.sv
// Index table delta encoder tb: directed and random streams checked against a byte predictor.
`timescale 1ns / 100ps

module tb import itde_pkg::*;;

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

  // One expected output byte and its end-of-item mark
  typedef struct packed {
    logic [7:0] code;
    logic       tail;
  } coded_byte_t;

  // Predicts the byte stream from the accepted values and checks every output transfer
  class delta_code_scoreboard;
    logic [30:0]  prev_val;
    logic [30:0]  prev2_val;
    int unsigned  run_len;
    coded_byte_t  expected_q[$];
    int unsigned  mismatches;

    function new();
      prev_val   = '0;
      prev2_val  = '0;
      run_len    = 0;
      mismatches = 0;
    endfunction

    function void push(logic [7:0] b);
      coded_byte_t e;
      e.code = b;
      e.tail = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void flush_run();
      if (run_len == 0) return;
      if (run_len == 1) begin
        push(RunOne);
      end else if (run_len < 16) begin
        push(RunShort + 8'(run_len));
      end else begin
        push(RunLong);
        push(8'(run_len - 16));
      end
      run_len = 0;
    endfunction

    function longint unsigned zigzag(longint e);
      if (e >= 0) return longint'(unsigned'(e)) << 1;
      return (longint'(unsigned'(-e)) << 1) - 1;
    endfunction

    // Work out the bytes that one accepted input transfer must cause
    function void note_input(logic [31:0] data, logic first, logic tail);
      logic [30:0]       v;
      longint            err;
      longint            dif;
      longint unsigned   z;
      longint unsigned   k;
      int unsigned       n0;
      coded_byte_t       e;
      v  = data[30:0];
      n0 = expected_q.size();
      if (first) begin
        prev_val  = '0;
        prev2_val = '0;
        run_len   = 0;
      end
      err = longint'(v) - (2 * longint'(prev_val) - longint'(prev2_val));
      dif = longint'(v) - longint'(prev_val);
      if (err == 0) begin
        run_len++;
        // full run goes out at once
        if (run_len >= 256) begin
          push(RunLong);
          push(RunLong);
          run_len = 0;
        end
      end else begin
        flush_run();
        z = zigzag(err);
        k = zigzag(dif);
        if (z < 128) begin
          push(8'(z));
        end else if (z < 16384) begin
          push(Zz2 | 8'(z >> 8));
          push(8'(z));
        end else if (k < 256) begin
          push(EscByte);
          push(8'(k));
        end else if (z < 2097152) begin
          push(Zz3 | 8'(z >> 16));
          push(8'(z >> 8));
          push(8'(z));
        end else if (k < 65536) begin
          push(EscWord);
          push(8'(k >> 8));
          push(8'(k));
        end else if (v < 31'd16777216) begin
          push(Lit3);
          push(8'(v >> 16));
          push(8'(v >> 8));
          push(8'(v));
        end else begin
          push(Lit4);
          push(8'(v >> 24));
          push(8'(v >> 16));
          push(8'(v >> 8));
          push(8'(v));
        end
      end
      prev2_val = prev_val;
      prev_val  = v;
      if (tail) flush_run();
      // mark the last byte of this item
      if (expected_q.size() > n0) begin
        e = expected_q.pop_back();
        e.tail = 1'b1;
        expected_q.push_back(e);
      end
    endfunction

    // Compare one output transfer with the oldest expected byte
    function void check_output(logic [7:0] b, logic tail);
      coded_byte_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected byte %02h last %0b", b, tail);
        return;
      end
      e = expected_q.pop_front();
      if (b !== e.code || tail !== e.tail) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: byte expected %02h last %0b, got %02h last %0b",
                   e.code, e.tail, b, tail);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  delta_code_scoreboard sb = new();

  // Stimulus generator state, follows the values in sending order
  logic [30:0] gen_prev  = '0;
  logic [30:0] gen_prev2 = '0;
  int unsigned item_count = 0;
  bit          no_idle = 1'b0;

  index_table_delta_encoder i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    if (no_idle) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic longint gen_pred();
    return 2 * longint'(gen_prev) - longint'(gen_prev2);
  endfunction

  // Drive one value transfer and note it in the scoreboard when accepted
  task automatic send_value(logic [30:0] v, logic first, logic tail);
    int unsigned gap;
    logic [31:0] data;
    gap  = idle_cycles();
    data = {($urandom_range(0, 15) == 0), v};
    if (first) begin
      gen_prev  = '0;
      gen_prev2 = '0;
    end
    gen_prev2 = gen_prev;
    gen_prev  = v;
    item_count++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= first;
    s_axis_tlast  <= tail;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(data, first, tail);
  endtask

  // A value off the prediction or the previous value by a random size class, or fully random
  function automatic logic [30:0] jump_value();
    longint c;
    longint p;
    p = gen_pred();
    case ($urandom_range(0, 7))
      0: c = p + longint'($urandom_range(0, 126)) - 63;
      1: c = p + longint'($urandom_range(0, 16382)) - 8191;
      2: c = p + longint'($urandom_range(0, 2097150)) - 1048575;
      3: c = longint'(gen_prev) + longint'($urandom_range(0, 254)) - 127;
      4: c = longint'(gen_prev) + longint'($urandom_range(0, 65534)) - 32767;
      5: c = longint'($urandom_range(0, 24'hFF_FFFF));
      6: c = longint'($urandom & ValueMax);
      default: c = longint'($urandom_range(0, 255));
    endcase
    if (c < 0 || c > longint'(ValueMax)) c = longint'($urandom & ValueMax);
    return c[30:0];
  endfunction

  // Values that meet the prediction, falling back to a jump when it leaves the range
  task automatic send_run(int unsigned len, logic tail_at_end);
    longint p;
    for (int unsigned i = 0; i < len; i++) begin
      p = gen_pred();
      if (p < 0 || p > longint'(ValueMax)) p = longint'(jump_value());
      send_value(p[30:0], 1'b0, tail_at_end && (i == len - 1));
    end
  endtask

  // Receiver: random stalls, check every output transfer
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_output(m_axis_tdata, m_axis_tlast);
    end
  end

  // Main sequence
  initial begin
    int unsigned random_end;
    int unsigned sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: run of one, run flushed at end, largest value, escapes, literals
    send_value(31'd0, 1'b1, 1'b0);
    send_value(31'd0, 1'b0, 1'b1);
    send_value(ValueMax, 1'b1, 1'b0);
    send_value(ValueMax, 1'b0, 1'b0);
    send_value(ValueMax, 1'b0, 1'b0);
    send_value(ValueMax - 31'd15, 1'b0, 1'b0);
    send_value(31'h00FF_FFFF, 1'b1, 1'b0);
    send_value(31'h00FF_FFFF + 31'd20000, 1'b0, 1'b0);
    send_value(31'h00FF_FFFF + 31'd540000, 1'b0, 1'b0);
    send_run(3, 1'b0);
    // new table drops the pending run
    send_value(31'd5, 1'b1, 1'b0);
    send_value(31'd5, 1'b0, 1'b0);
    // long run flushed by end of table
    send_run(16, 1'b1);

    // Run of 256 to 280 values for the full-run flush, unless the prediction leaves the range
    send_value(31'($urandom_range(0, 1000)), 1'b1, 1'b0);
    send_value(31'($urandom_range(0, 1000)), 1'b0, 1'b0);
    send_run($urandom_range(256, 280), 1'($urandom_range(0, 1)));

    // Random tables until about 410 values in all: mostly runs and jumps, some noise
    random_end = 410;
    while (item_count < random_end) begin
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_value(jump_value(), 1'b1, ($urandom_range(0, 9) == 0));
      end else if (sel < 45) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          send_run($urandom_range(1, 6), ($urandom_range(0, 9) == 0));
        else if (sel < 95)
          send_run($urandom_range(10, 40), ($urandom_range(0, 3) == 0));
        else
          send_run($urandom_range(1, 3), 1'b1);
      end else if (sel < 90) begin
        send_value(jump_value(), 1'b0, ($urandom_range(0, 11) == 0));
      end else begin
        send_value(31'($urandom & ValueMax), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

### files.f
rtl/itde_pkg.sv
rtl/itde_front.sv
rtl/itde_queue.sv
rtl/itde_back.sv
rtl/index_table_delta_encoder.sv
test/tb.sv
